// ----- rtl/nr1d_pkg.sv -----
// Shared constants, types and helpers for the 1-D nearest-neighbor resizer.
package nr1d_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_RUN       = 64;
  localparam int SAMPLE_BITS   = 32;
  localparam int WIDTH_BITS    = 13;
  localparam int POS_BITS      = 12;
  localparam int SCALE_BITS    = 29;
  localparam int COORD_BITS    = 40;
  localparam int IDX_BITS      = COORD_BITS - 16;
  localparam int PROD_BITS     = WIDTH_BITS + 1 + SCALE_BITS;
  localparam int EMIT_BITS     = $clog2(MAX_RUN + 1);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SCALE_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IN_WIDTH   = 3'd0,
    CFG_OUT_WIDTH  = 3'd1,
    CFG_SCALE      = 3'd2,
    CFG_ALIGN      = 3'd3,
    CFG_HALF_PIXEL = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] iw;
    logic [WIDTH_BITS-1:0] ow;
    logic [SCALE_BITS-1:0] scale;
    logic                  align;
    logic                  half;
  } nr1d_cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [POS_BITS-1:0]    src_pos;
    logic                   is_last;
  } nr1d_item_t;

  function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] v);
    logic [WIDTH_BITS-1:0] r;
    if (v == '0) begin
      r = WIDTH_BITS'(1);
    end else if (v > WIDTH_BITS'(MAX_WIDTH)) begin
      r = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/nr1d_front.sv -----
// Front end: accepts input samples, tracks the input position and tags the row's last sample.
module nr1d_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nr1d_pkg::SAMPLE_BITS-1:0]  in_sample_bits,
  input  nr1d_pkg::nr1d_cfg_t               cfg,
  input  logic                              q_full,
  output logic                              q_push,
  output nr1d_pkg::nr1d_item_t              q_item
);
  import nr1d_pkg::*;

  logic [POS_BITS-1:0]   in_pos_r;
  logic [POS_BITS-1:0]   in_pos_nxt;
  logic [WIDTH_BITS-1:0] last_idx;
  logic                  is_last;

  assign last_idx = cfg.iw - WIDTH_BITS'(1);
  assign is_last  = {1'b0, in_pos_r} >= last_idx;
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  assign q_item.sample  = in_sample_bits;
  assign q_item.src_pos = in_pos_r;
  assign q_item.is_last = is_last;

  always_comb begin
    in_pos_nxt = in_pos_r;
    if (q_push) begin
      in_pos_nxt = is_last ? '0 : in_pos_r + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r <= '0;
    end else begin
      in_pos_r <= in_pos_nxt;
    end
  end

endmodule

// ----- rtl/nr1d_queue.sv -----
// Short request queue between the front end and the output sequencer.
module nr1d_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nr1d_pkg::nr1d_item_t wr_item,
  input  logic                 pop,
  output nr1d_pkg::nr1d_item_t rd_item,
  output logic                 full,
  output logic                 empty
);
  import nr1d_pkg::*;

  nr1d_item_t           entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_nxt;

  assign full    = count_r == QCNT_BITS'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_item = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ----- rtl/nr1d_back.sv -----
// Back end: walks output positions for each request, then emits the run through an output register.
module nr1d_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nr1d_pkg::nr1d_cfg_t               cfg,
  input  logic                              cfg_we,
  input  logic                              q_empty,
  input  nr1d_pkg::nr1d_item_t              q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nr1d_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                              out_row_end,
  output logic                              out_run_last,
  output logic                              out_run_truncated
);
  import nr1d_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [POS_BITS-1:0]    src_pos_r, src_pos_nxt;
  logic                   is_last_r, is_last_nxt;
  logic [WIDTH_BITS-1:0]  out_pos_r, out_pos_nxt;
  logic [COORD_BITS-1:0]  coord_r, coord_nxt;
  logic                   stale_r, stale_nxt;
  logic [WIDTH_BITS-1:0]  run_cnt_r, run_cnt_nxt;
  logic                   reached_r, reached_nxt;
  logic [EMIT_BITS-1:0]   emit_left_r, emit_left_nxt;
  logic                   trunc_r, trunc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_row_end_r, out_row_end_nxt;
  logic                   out_run_last_r, out_run_last_nxt;
  logic                   out_trunc_r, out_trunc_nxt;

  logic [COORD_BITS:0]    step_sum;
  logic [COORD_BITS-1:0]  coord_step;
  logic [COORD_BITS:0]    rnd_sum;
  logic [IDX_BITS-1:0]    src_idx;
  logic                   take;
  logic [WIDTH_BITS:0]    mul_a;
  logic [PROD_BITS-1:0]   prod;
  logic [COORD_BITS-1:0]  coord_load;
  logic                   run_trunc;
  logic [EMIT_BITS-1:0]   run_emit;
  logic                   out_load;
  logic                   emit_last;

  // Q.17 coordinate, saturating
  assign step_sum   = {1'b0, coord_r} + (COORD_BITS + 1)'({cfg.scale, 1'b0});
  assign coord_step = step_sum[COORD_BITS] ? '1 : step_sum[COORD_BITS-1:0];
  assign rnd_sum    = {1'b0, coord_r} + (COORD_BITS + 1)'(65536);
  assign src_idx    = cfg.align ? rnd_sum[COORD_BITS:17] : {1'b0, coord_r[COORD_BITS-1:17]};
  assign take       = (out_pos_r < cfg.ow) &&
                      (is_last_r || (src_idx <= IDX_BITS'(src_pos_r)));

  assign mul_a      = {out_pos_r, cfg.half};
  assign prod       = PROD_BITS'(mul_a) * PROD_BITS'(cfg.scale);
  assign coord_load = (|prod[PROD_BITS-1:COORD_BITS]) ? '1 : prod[COORD_BITS-1:0];

  assign run_trunc  = run_cnt_r > WIDTH_BITS'(MAX_RUN);
  assign run_emit   = run_trunc ? EMIT_BITS'(MAX_RUN) : run_cnt_r[EMIT_BITS-1:0];

  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last  = emit_left_r == EMIT_BITS'(1);
  assign q_pop      = (state_r == ST_IDLE) && !q_empty;

  assign out_valid         = out_valid_r;
  assign out_sample        = out_sample_r;
  assign out_row_end       = out_row_end_r;
  assign out_run_last      = out_run_last_r;
  assign out_run_truncated = out_trunc_r;

  always_comb begin
    state_nxt        = state_r;
    sample_nxt       = sample_r;
    src_pos_nxt      = src_pos_r;
    is_last_nxt      = is_last_r;
    out_pos_nxt      = out_pos_r;
    coord_nxt        = coord_r;
    stale_nxt        = stale_r;
    run_cnt_nxt      = run_cnt_r;
    reached_nxt      = reached_r;
    emit_left_nxt    = emit_left_r;
    trunc_nxt        = trunc_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_sample_nxt   = out_sample_r;
    out_row_end_nxt  = out_row_end_r;
    out_run_last_nxt = out_run_last_r;
    out_trunc_nxt    = out_trunc_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          sample_nxt  = q_item.sample;
          src_pos_nxt = q_item.src_pos;
          is_last_nxt = q_item.is_last;
          run_cnt_nxt = '0;
          reached_nxt = 1'b0;
          state_nxt   = stale_r ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: begin
        coord_nxt = coord_load;
        stale_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (take) begin
          run_cnt_nxt = run_cnt_r + WIDTH_BITS'(1);
          out_pos_nxt = out_pos_r + WIDTH_BITS'(1);
          coord_nxt   = coord_step;
          if (out_pos_r + WIDTH_BITS'(1) == cfg.ow) begin
            reached_nxt = 1'b1;
          end
        end else begin
          emit_left_nxt = run_emit;
          trunc_nxt     = run_trunc;
          if (is_last_r) begin
            out_pos_nxt = '0;
            coord_nxt   = cfg.half ? COORD_BITS'(cfg.scale) : '0;
          end
          state_nxt = (run_cnt_r == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt    = 1'b1;
          out_sample_nxt   = sample_r;
          out_run_last_nxt = emit_last;
          out_row_end_nxt  = emit_last & reached_r;
          out_trunc_nxt    = trunc_r;
          emit_left_nxt    = emit_left_r - EMIT_BITS'(1);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // any configuration write: rebuild the coordinate on the next request
    if (cfg_we) begin
      stale_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_pos_r   <= '0;
      coord_r     <= '0;
      stale_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_pos_r   <= out_pos_nxt;
      coord_r     <= coord_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r       <= sample_nxt;
    src_pos_r      <= src_pos_nxt;
    is_last_r      <= is_last_nxt;
    run_cnt_r      <= run_cnt_nxt;
    reached_r      <= reached_nxt;
    emit_left_r    <= emit_left_nxt;
    trunc_r        <= trunc_nxt;
    out_sample_r   <= out_sample_nxt;
    out_row_end_r  <= out_row_end_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_trunc_r    <= out_trunc_nxt;
  end

endmodule

// ----- rtl/nearest_resize_1d.sv -----
// Top level of the streaming 1-D nearest-neighbor resizer.
// Each input sample is copied to every output position whose source index it is; the row's
// last sample also covers all remaining positions, and a run above 64 results is cut to 64
// with run_truncated set on each of its results. For each request the output sequencer
// walks the output positions the sample covers (dropped ones included), then delivers its
// results; the first request after a configuration write first rebuilds the coordinate with
// the multiplier. The sequencer steps one output position per cycle, then one result per
// cycle while the output is not stalled; a two-entry queue lets the input side keep taking
// samples meanwhile.
module nearest_resize_1d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nr1d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [nr1d_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nr1d_pkg::SAMPLE_BITS-1:0]    in_sample_bits,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nr1d_pkg::SAMPLE_BITS-1:0]    out_sample,
  output logic                                out_row_end,
  output logic                                out_run_last,
  output logic                                out_run_truncated
);
  import nr1d_pkg::*;

  logic [WIDTH_BITS-1:0] in_width_r;
  logic [WIDTH_BITS-1:0] out_width_r;
  logic [SCALE_BITS-1:0] scale_r;
  logic                  align_r;
  logic                  half_r;
  nr1d_cfg_t             cfg;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  nr1d_item_t            q_wr_item;
  nr1d_item_t            q_rd_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= WIDTH_BITS'(1);
      out_width_r <= WIDTH_BITS'(1);
      scale_r     <= SCALE_BITS'(65536);
      align_r     <= 1'b0;
      half_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IN_WIDTH:   in_width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        CFG_OUT_WIDTH:  out_width_r <= cfg_wdata[WIDTH_BITS-1:0];
        CFG_SCALE:      scale_r     <= cfg_wdata[SCALE_BITS-1:0];
        CFG_ALIGN:      align_r     <= cfg_wdata[0];
        CFG_HALF_PIXEL: half_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.iw    = eff_width(in_width_r);
  assign cfg.ow    = eff_width(out_width_r);
  assign cfg.scale = scale_r;
  assign cfg.align = align_r;
  assign cfg.half  = half_r;

  nr1d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_bits (in_sample_bits),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wr_item)
  );

  nr1d_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  nr1d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cfg_we            (cfg_we),
    .q_empty           (q_empty),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_row_end       (out_row_end),
    .out_run_last      (out_run_last),
    .out_run_truncated (out_run_truncated)
  );

  a_row_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_run_last)
    else $error("row end on a result that is not last of its run");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("request queue reports full and empty");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request popped from empty queue");

endmodule
